// File: hw/rtl/dkvt_pkg.sv
// ----------------------------------------------------------------------------
// dkvt_pkg
// Shared sizes, command and status codes for the descriptor key/value table.
// ----------------------------------------------------------------------------
package dkvt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;

  localparam logic [KEY_W-1:0] FIRST_KEY = KEY_W'(2);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_POP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

endpackage

// File: hw/rtl/dkvt_req_if.sv
// ----------------------------------------------------------------------------
// dkvt_req_if
// Command channel into the descriptor key/value table.
// ----------------------------------------------------------------------------
interface dkvt_req_if;
  import dkvt_pkg::*;

  logic               valid;
  logic               ready;
  cmd_t               command;
  logic [KEY_W-1:0]   lookup_key;
  logic [VAL_W-1:0]   stored_value;

  modport source (output valid, output command, output lookup_key, output stored_value,
                  input ready);
  modport sink (input valid, input command, input lookup_key, input stored_value,
                output ready);
endinterface

// File: hw/rtl/dkvt_rsp_if.sv
// ----------------------------------------------------------------------------
// dkvt_rsp_if
// Response channel out of the descriptor key/value table.
// ----------------------------------------------------------------------------
interface dkvt_rsp_if;
  import dkvt_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic [KEY_W-1:0]   result_key;
  logic [VAL_W-1:0]   result_value;

  modport source (output valid, output status, output result_key, output result_value,
                  input ready);
  modport sink (input valid, input status, input result_key, input result_value,
                output ready);
endinterface

// File: hw/rtl/descriptor_key_value_table.sv
// ----------------------------------------------------------------------------
// descriptor_key_value_table
// Fixed table of key/value entries that hands out rising keys.
// ----------------------------------------------------------------------------
// Each command transfer (insert, find, remove, pop oldest) yields exactly one
// response transfer. One command is worked on at a time, in order: a sweep
// of the key memory through its single read port, one entry per cycle; a
// fetch step that updates the table and reads the value memory; and a load
// step that fills the response register once that register is free. The
// response sits in its own register, so a new command is taken while an older
// response still waits for its transfer. Keys start at 2 and count up; after
// key 0xFFFFFFFF is handed out every insert reports full. Valid marks clear
// at reset; key and value contents are not cleared.
// ----------------------------------------------------------------------------
module descriptor_key_value_table (
  input  logic       clk,
  input  logic       rst,
  dkvt_req_if.sink   req,
  dkvt_rsp_if.source rsp
);
  import dkvt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FETCH = 4'b0100,
    S_LOAD  = 4'b1000
  } state_t;

  state_t state;

  // Latched command
  cmd_t             cmd;
  logic [KEY_W-1:0] lookup_key;
  logic [VAL_W-1:0] stored_value;

  // Storage: key and value memories, valid marks in flops
  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [VAL_W-1:0] val_mem [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [KEY_W-1:0] key_counter;

  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  // Sweep bookkeeping
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] eval_idx;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             old_found;
  logic [IDX_W-1:0] old_idx;
  logic [KEY_W-1:0] old_key;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // Pending result
  status_t          res_status;
  logic [KEY_W-1:0] res_key;

  // Response register
  logic             out_valid;
  status_t          out_status;
  logic [KEY_W-1:0] out_key;
  logic [VAL_W-1:0] out_value;

  logic             req_fire;
  logic             scan_issue;
  logic             scan_eval;
  logic             scan_last;
  logic [IDX_W-1:0] scan_addr;
  logic             ev_valid;
  logic             ev_match;
  logic             ev_older;
  logic             ins_ok;
  logic             key_we;
  logic [IDX_W-1:0] val_raddr;
  logic             load_fire;

  assign req.ready  = (state == S_IDLE);
  assign req_fire   = req.valid && req.ready;

  // Sweep: issue a read at cnt, judge the entry read on the previous cycle
  assign scan_issue = (state == S_SCAN) && (cnt != CNT_W'(ENTRIES));
  assign scan_eval  = (state == S_SCAN) && (cnt != '0);
  assign scan_last  = (state == S_SCAN) && (cnt == CNT_W'(ENTRIES));
  assign scan_addr  = cnt[IDX_W-1:0];

  assign ev_valid   = entry_valid[eval_idx];
  assign ev_match   = ev_valid && (key_q == lookup_key);
  assign ev_older   = ev_valid && (!old_found || (key_q < old_key));

  // An insert needs a free entry and a counter that has not wrapped below 2
  assign ins_ok     = free_found && (key_counter >= FIRST_KEY);
  assign key_we     = (state == S_FETCH) && (cmd == CMD_INSERT) && ins_ok;
  assign val_raddr  = (cmd == CMD_POP) ? old_idx : hit_idx;

  assign load_fire  = (state == S_LOAD) && (!out_valid || rsp.ready);

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[free_idx] <= key_counter;
    end
    if (scan_issue) begin
      key_q <= key_mem[scan_addr];
    end
  end

  // Value memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (key_we) begin
      val_mem[free_idx] <= stored_value;
    end
    if (state == S_FETCH) begin
      val_q <= val_mem[val_raddr];
    end
  end

  // Control: sequencer, valid marks, key counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      key_counter <= FIRST_KEY;
      cnt         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + CNT_W'(1);
          if (scan_last) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          unique case (cmd)
            CMD_INSERT: begin
              if (ins_ok) begin
                entry_valid[free_idx] <= 1'b1;
                key_counter           <= key_counter + KEY_W'(1);
              end
            end
            CMD_FIND: begin
            end
            CMD_REMOVE: begin
              if (hit) begin
                entry_valid[hit_idx] <= 1'b0;
              end
            end
            CMD_POP: begin
              if (old_found) begin
                entry_valid[old_idx] <= 1'b0;
              end
            end
            default: begin
            end
          endcase
          state <= S_LOAD;
        end
        S_LOAD: begin
          // Hold until the response register is free
          if (load_fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command capture and sweep results
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd          <= req.command;
      lookup_key   <= req.lookup_key;
      stored_value <= req.stored_value;
      hit          <= 1'b0;
      old_found    <= 1'b0;
      free_found   <= 1'b0;
    end
    if (scan_issue) begin
      eval_idx <= scan_addr;
    end
    if (scan_eval) begin
      // First match wins, lowest free index wins, smallest key wins
      if (ev_match && !hit) begin
        hit     <= 1'b1;
        hit_idx <= eval_idx;
      end
      if (ev_older) begin
        old_found <= 1'b1;
        old_idx   <= eval_idx;
        old_key   <= key_q;
      end
      if (!ev_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= eval_idx;
      end
    end
    if (state == S_FETCH) begin
      res_key <= '0;
      unique case (cmd)
        CMD_INSERT: begin
          res_status <= ins_ok ? ST_OK : ST_FULL;
          if (ins_ok) begin
            res_key <= key_counter;
          end
        end
        CMD_FIND, CMD_REMOVE: begin
          res_status <= hit ? ST_OK : ST_NOT_FOUND;
        end
        CMD_POP: begin
          res_status <= old_found ? ST_OK : ST_NOT_FOUND;
          if (old_found) begin
            res_key <= old_key;
          end
        end
        default: begin
          res_status <= ST_NOT_FOUND;
        end
      endcase
    end
  end

  // Response register: drop on transfer, load when the item finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      out_status <= res_status;
      out_key    <= res_key;
      out_value  <= ((res_status == ST_OK) && (cmd != CMD_INSERT)) ? val_q : '0;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.result_key   = out_key;
  assign rsp.result_value = out_value;

endmodule

// File: tb/dkvt_table_checker.sv
// ----------------------------------------------------------------------------
// dkvt_table_checker
// Watches both channels of the key/value table, predicts every response
// from a shadow copy of the table and compares it field by field.
// ----------------------------------------------------------------------------
module dkvt_table_checker
  import dkvt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dkvt_req_if  req,
  dkvt_rsp_if  rsp,
  output int   failures,
  output int   pending,
  output int   ok_seen,
  output int   miss_seen,
  output int   full_seen
);

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } table_rsp_t;

  logic [KEY_W-1:0] shadow_key   [ENTRIES];
  logic [VAL_W-1:0] shadow_value [ENTRIES];
  logic             shadow_live  [ENTRIES];
  logic [KEY_W-1:0] shadow_counter;
  table_rsp_t       awaited_rsp  [$];
  table_rsp_t       got_rsp;
  table_rsp_t       want_rsp;

  // Apply one command to the shadow table and return its response.
  function automatic table_rsp_t apply_command(cmd_t cmd, logic [KEY_W-1:0] key,
                                               logic [VAL_W-1:0] value);
    table_rsp_t r;
    int         slot;
    r    = '{ST_NOT_FOUND, '0, '0};
    slot = -1;
    case (cmd)
      CMD_INSERT: begin
        for (int i = ENTRIES - 1; i >= 0; i--) if (!shadow_live[i]) slot = i;
        if (slot < 0 || shadow_counter < FIRST_KEY) begin
          r.status = ST_FULL;
        end else begin
          shadow_key[slot]   = shadow_counter;
          shadow_value[slot] = value;
          shadow_live[slot]  = 1'b1;
          r.status           = ST_OK;
          r.key              = shadow_counter;
          shadow_counter     = shadow_counter + KEY_W'(1);
        end
      end
      CMD_FIND, CMD_REMOVE: begin
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_live[i] && shadow_key[i] == key) slot = i;
        if (slot >= 0) begin
          r.status = ST_OK;
          r.value  = shadow_value[slot];
          if (cmd == CMD_REMOVE) shadow_live[slot] = 1'b0;
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_live[i] && (slot < 0 || shadow_key[i] < shadow_key[slot])) slot = i;
        if (slot >= 0) begin
          r.status          = ST_OK;
          r.key             = shadow_key[slot];
          r.value           = shadow_value[slot];
          shadow_live[slot] = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        shadow_key[i]   = '0;
        shadow_value[i] = '0;
        shadow_live[i]  = 1'b0;
      end
      shadow_counter = FIRST_KEY;
      awaited_rsp.delete();
      failures  = 0;
      ok_seen   = 0;
      miss_seen = 0;
      full_seen = 0;
    end else begin
      // Check the response first: it can never belong to a command taken now.
      if (rsp.valid && rsp.ready) begin
        got_rsp = '{rsp.status, rsp.result_key, rsp.result_value};
        case (got_rsp.status)
          ST_OK:        ok_seen++;
          ST_NOT_FOUND: miss_seen++;
          default:      full_seen++;
        endcase
        if (awaited_rsp.size() == 0) begin
          $error("response transfer with no command outstanding: status %0d", got_rsp.status);
          failures++;
        end else begin
          want_rsp = awaited_rsp[0];
          awaited_rsp.delete(0);
          if (got_rsp.status !== want_rsp.status) begin
            $error("status: expected %0d, got %0d", want_rsp.status, got_rsp.status);
            failures++;
          end
          if (got_rsp.key !== want_rsp.key) begin
            $error("result_key: expected %h, got %h", want_rsp.key, got_rsp.key);
            failures++;
          end
          if (got_rsp.value !== want_rsp.value) begin
            $error("result_value: expected %h, got %h", want_rsp.value, got_rsp.value);
            failures++;
          end
        end
      end
      if (req.valid && req.ready)
        awaited_rsp.push_back(apply_command(req.command, req.lookup_key, req.stored_value));
    end
    pending = awaited_rsp.size();
  end

endmodule

// File: tb/descriptor_key_value_table_tb.sv
// ----------------------------------------------------------------------------
// descriptor_key_value_table_tb
// Drives commands into the key/value table and gives the verdict.
// ----------------------------------------------------------------------------
// A directed opening covers the empty table, a full table, value extremes,
// slot reuse and oldest-entry pops. Random traffic follows in four pacing
// phases, alternating fill-heavy and drain-heavy stretches so the table
// swings between empty and full. Lookup keys mostly fall among recently
// handed-out keys so finds and removes hit; the rest are full-range noise.
// The key counter cannot be run to its end from the ports in a run of this
// length, so status full is reached here through a full table only.
// ----------------------------------------------------------------------------
module descriptor_key_value_table_tb;
  import dkvt_pkg::*;

  localparam int PHASE_ITEMS  = 125;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4 * (ENTRIES + 4);
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst;

  dkvt_req_if req ();
  dkvt_rsp_if rsp ();

  int failures;
  int pending;
  int ok_seen;
  int miss_seen;
  int full_seen;

  // Pacing knobs, set per phase by the stimulus process.
  int idle_pct;
  int stall_pct;
  // Long hold-off handshake: stimulus bumps hold_asks, the receiver serves it.
  int hold_asks;
  int hold_done;
  int hold_left;

  int               cycles;
  int               cmd_sent [4];
  logic [KEY_W-1:0] inserts_sent;

  descriptor_key_value_table dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  dkvt_table_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .failures  (failures),
    .pending   (pending),
    .ok_seen   (ok_seen),
    .miss_seen (miss_seen),
    .full_seen (full_seen)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Response side: serve a pending long hold-off first, else stall at random.
  always @(negedge clk) begin
    if (hold_done != hold_asks) begin
      hold_done = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one command and hold it until its transfer. Entered and left at a
  // falling edge; valid is only touched once per edge.
  task automatic send_item(input cmd_t cmd, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid        <= 1'b1;
    req.command      <= cmd;
    req.lookup_key   <= key;
    req.stored_value <= value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    cmd_sent[cmd]++;
    if (cmd == CMD_INSERT) inserts_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding response to come back.
  task automatic wait_for_drain();
    req.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Build one random command. fill_pct sets the share of inserts.
  task automatic send_random(input int fill_pct);
    int               roll;
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] lo;
    logic [KEY_W-1:0] key;
    cmd_t             cmd;
    roll = $urandom_range(99);
    if (roll < fill_pct) cmd = CMD_INSERT;
    else begin
      case ($urandom_range(2))
        0:       cmd = CMD_FIND;
        1:       cmd = CMD_REMOVE;
        default: cmd = CMD_POP;
      endcase
    end
    // Keep most lookups near the keys handed out lately so they hit.
    hi   = FIRST_KEY + inserts_sent;
    lo   = (hi > 40) ? hi - 40 : FIRST_KEY;
    roll = $urandom_range(99);
    if (roll < 80)      key = $urandom_range(hi, lo);
    else if (roll < 90) key = $urandom;
    else begin
      case ($urandom_range(3))
        0:       key = '0;
        1:       key = 32'h0000_0001;
        2:       key = 32'h8000_0000;
        default: key = '1;
      endcase
    end
    send_item(cmd, key, $urandom);
  endtask

  initial begin
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.command      = CMD_INSERT;
    req.lookup_key   = '0;
    req.stored_value = '0;
    rsp.ready        = 1'b0;
    idle_pct         = 0;
    stall_pct        = 0;
    hold_asks        = 0;
    hold_done        = 0;
    hold_left        = 0;
    cycles           = 0;
    inserts_sent     = '0;
    foreach (cmd_sent[i]) cmd_sent[i] = 0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty table: pop, find and remove all miss.
    send_item(CMD_POP,    32'h1234_5678, 32'hFFFF_FFFF);
    send_item(CMD_FIND,   '0,            '0);
    send_item(CMD_REMOVE, '1,            '1);
    // Fill every slot, values at both extremes and alternating patterns.
    send_item(CMD_INSERT, '1, '0);
    send_item(CMD_INSERT, '0, '1);
    for (int i = 2; i < ENTRIES; i++)
      send_item(CMD_INSERT, $urandom, (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555);
    // Insert into a full table.
    send_item(CMD_INSERT, '0, 32'hDEAD_BEEF);
    // Hit the first and last keys handed out.
    send_item(CMD_FIND, FIRST_KEY, '0);
    send_item(CMD_FIND, FIRST_KEY + ENTRIES - 1, '1);
    // Free a middle slot, then reuse it with the next key.
    send_item(CMD_REMOVE, FIRST_KEY + 3, '0);
    send_item(CMD_INSERT, '1, 32'h0BAD_F00D);
    // Oldest entries leave first.
    send_item(CMD_POP, '0, '0);
    send_item(CMD_POP, '1, '1);
    wait_for_drain();

    // Random traffic over four pacing phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 67; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Back up the response side while commands keep coming.
        if (phase == 0 && n == 40) hold_asks++;
        send_random(((n / 25) % 2 == 0) ? 70 : 20);
      end
      // Pause the sender until the table has answered everything.
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d inserts, %0d finds, %0d removes, %0d pops over four pacing phases",
             cmd_sent[CMD_INSERT], cmd_sent[CMD_FIND], cmd_sent[CMD_REMOVE], cmd_sent[CMD_POP]);
    $display("with a long response hold-off; responses ok %0d, not found %0d, full %0d",
             ok_seen, miss_seen, full_seen);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
